@@ hw/rtl/mpd_pkg.sv @@
package mpd_pkg;

    typedef logic [7:0] t_byte;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SYNC_FIRST        = 3'd0;
    localparam t_cfg_idx CFG_SYNC_SECOND       = 3'd1;
    localparam t_cfg_idx CFG_CHECK_ACK         = 3'd2;
    localparam t_cfg_idx CFG_EXPECTED_DESC_SET = 3'd3;
    localparam t_cfg_idx CFG_EXPECTED_CMD      = 3'd4;

    localparam t_byte SYNC_FIRST_RESET  = 8'h75;
    localparam t_byte SYNC_SECOND_RESET = 8'h65;
    localparam t_byte ACK_OK_CODE       = 8'h00;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_SUM   = 3'd1;
    localparam t_status ST_TOO_SHORT = 3'd2;
    localparam t_status ST_WRONG_SET = 3'd3;
    localparam t_status ST_WRONG_ECHO = 3'd4;
    localparam t_status ST_NACK      = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam t_byte MIN_ACK_LENGTH = 8'd4;
    localparam t_byte ECHO_INDEX     = 8'd2;
    localparam t_byte ERROR_INDEX    = 8'd3;

    typedef struct packed {
        t_byte sync_first;
        t_byte sync_second;
        logic  check_ack;
        t_byte expected_desc_set;
        t_byte expected_cmd;
    } t_cfg;

    typedef struct packed {
        logic    kind;
        t_byte   data_byte;
        t_byte   byte_index;
        t_status status;
        t_byte   desc_set;
        t_byte   payload_length;
    } t_result;

endpackage

@@ hw/rtl/mpd_if.sv @@
interface mpd_in_if;
    logic          valid;
    logic          ready;
    mpd_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_out_if;
    logic            valid;
    logic            ready;
    logic            kind;
    mpd_pkg::t_byte   data_byte;
    mpd_pkg::t_byte   byte_index;
    mpd_pkg::t_status status;
    mpd_pkg::t_byte   desc_set;
    mpd_pkg::t_byte   payload_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output status, output desc_set, output payload_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input status, input desc_set, input payload_length, output ready);
endinterface

interface mpd_cfg_if;
    logic              valid;
    logic              ready;
    mpd_pkg::t_cfg_idx index;
    mpd_pkg::t_byte    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mpd_cfg_regs.sv @@
module mpd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mpd_cfg_if.sink       i_cfg,
    output mpd_pkg::t_cfg o_cfg
);

    mpd_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first        <= mpd_pkg::SYNC_FIRST_RESET;
            r_cfg.sync_second       <= mpd_pkg::SYNC_SECOND_RESET;
            r_cfg.check_ack         <= 1'b0;
            r_cfg.expected_desc_set <= '0;
            r_cfg.expected_cmd      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mpd_pkg::CFG_SYNC_FIRST:        r_cfg.sync_first <= i_cfg.data;
                mpd_pkg::CFG_SYNC_SECOND:       r_cfg.sync_second <= i_cfg.data;
                mpd_pkg::CFG_CHECK_ACK:         r_cfg.check_ack <= i_cfg.data[0];
                mpd_pkg::CFG_EXPECTED_DESC_SET: r_cfg.expected_desc_set <= i_cfg.data;
                mpd_pkg::CFG_EXPECTED_CMD:      r_cfg.expected_cmd <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/mpd_core.sv @@
module mpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpd_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mpd_pkg::t_byte   i_rx_byte,
    output logic             o_res_valid,
    output mpd_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_DESC    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHK1    = 3'd5;
    localparam logic [2:0] PH_CHK2    = 3'd6;

    logic           r_in_valid;
    mpd_pkg::t_byte r_in_byte;

    logic [2:0]     r_phase, n_phase;
    mpd_pkg::t_byte r_sum_low, n_sum_low;
    mpd_pkg::t_byte r_sum_high, n_sum_high;
    mpd_pkg::t_byte r_held_desc_set, n_held_desc_set;
    mpd_pkg::t_byte r_held_length, n_held_length;
    mpd_pkg::t_byte r_byte_count, n_byte_count;
    mpd_pkg::t_byte r_first_check_byte, n_first_check_byte;
    mpd_pkg::t_byte r_echo_byte, n_echo_byte;
    mpd_pkg::t_byte r_error_byte, n_error_byte;

    logic             advance;
    logic             emit;
    mpd_pkg::t_byte   count_inc;
    mpd_pkg::t_byte   sync_low;
    mpd_pkg::t_status st;

    assign advance    = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;
    assign count_inc  = r_byte_count + 8'd1;
    assign sync_low   = i_cfg.sync_first + i_cfg.sync_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        if (r_first_check_byte != r_sum_low || r_in_byte != r_sum_high) begin
            st = mpd_pkg::ST_BAD_SUM;
        end else if (!i_cfg.check_ack) begin
            st = mpd_pkg::ST_OK;
        end else if (r_held_length < mpd_pkg::MIN_ACK_LENGTH) begin
            st = mpd_pkg::ST_TOO_SHORT;
        end else if (r_held_desc_set != i_cfg.expected_desc_set) begin
            st = mpd_pkg::ST_WRONG_SET;
        end else if (r_echo_byte != i_cfg.expected_cmd) begin
            st = mpd_pkg::ST_WRONG_ECHO;
        end else if (r_error_byte != mpd_pkg::ACK_OK_CODE) begin
            st = mpd_pkg::ST_NACK;
        end else begin
            st = mpd_pkg::ST_OK;
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_sum_low          = r_sum_low;
        n_sum_high         = r_sum_high;
        n_held_desc_set    = r_held_desc_set;
        n_held_length      = r_held_length;
        n_byte_count       = r_byte_count;
        n_first_check_byte = r_first_check_byte;
        n_echo_byte        = r_echo_byte;
        n_error_byte       = r_error_byte;
        emit               = 1'b0;
        o_res.kind           = mpd_pkg::KIND_PAYLOAD;
        o_res.data_byte      = '0;
        o_res.byte_index     = '0;
        o_res.status         = mpd_pkg::ST_OK;
        o_res.desc_set       = r_held_desc_set;
        o_res.payload_length = r_held_length;
        unique case (r_phase)
            PH_HUNT2: begin
                if (r_in_byte == i_cfg.sync_second) begin
                    n_sum_low    = sync_low;
                    n_sum_high   = i_cfg.sync_first + sync_low;
                    n_echo_byte  = '0;
                    n_error_byte = '0;
                    n_byte_count = '0;
                    n_phase      = PH_DESC;
                end else if (r_in_byte != i_cfg.sync_first) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_DESC: begin
                n_held_desc_set = r_in_byte;
                n_sum_low       = r_sum_low + r_in_byte;
                n_sum_high      = r_sum_high + n_sum_low;
                n_phase         = PH_LEN;
            end
            PH_LEN: begin
                n_held_length = r_in_byte;
                n_sum_low     = r_sum_low + r_in_byte;
                n_sum_high    = r_sum_high + n_sum_low;
                n_byte_count  = '0;
                n_phase       = (r_in_byte == 8'd0) ? PH_CHK1 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_low  = r_sum_low + r_in_byte;
                n_sum_high = r_sum_high + n_sum_low;
                if (r_byte_count == mpd_pkg::ECHO_INDEX) begin
                    n_echo_byte = r_in_byte;
                end
                if (r_byte_count == mpd_pkg::ERROR_INDEX) begin
                    n_error_byte = r_in_byte;
                end
                emit             = 1'b1;
                o_res.data_byte  = r_in_byte;
                o_res.byte_index = r_byte_count;
                n_byte_count     = count_inc;
                if (count_inc == r_held_length) begin
                    n_phase = PH_CHK1;
                end
            end
            PH_CHK1: begin
                n_first_check_byte = r_in_byte;
                n_phase            = PH_CHK2;
            end
            PH_CHK2: begin
                emit         = 1'b1;
                o_res.kind   = mpd_pkg::KIND_STATUS;
                o_res.status = st;
                n_phase      = PH_HUNT1;
            end
            default: begin
                n_phase = (r_in_byte == i_cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    assign o_res_valid = advance && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HUNT1;
            r_sum_low          <= '0;
            r_sum_high         <= '0;
            r_held_desc_set    <= '0;
            r_held_length      <= '0;
            r_byte_count       <= '0;
            r_first_check_byte <= '0;
            r_echo_byte        <= '0;
            r_error_byte       <= '0;
        end else if (advance) begin
            r_phase            <= n_phase;
            r_sum_low          <= n_sum_low;
            r_sum_high         <= n_sum_high;
            r_held_desc_set    <= n_held_desc_set;
            r_held_length      <= n_held_length;
            r_byte_count       <= n_byte_count;
            r_first_check_byte <= n_first_check_byte;
            r_echo_byte        <= n_echo_byte;
            r_error_byte       <= n_error_byte;
        end
    end

    a_res_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_in_valid && i_res_ready)
        else $error("result issued without a pending item");

    a_payload_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == mpd_pkg::KIND_PAYLOAD) |-> o_res.status == mpd_pkg::ST_OK)
        else $error("payload result carries a status code");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_phase == PH_PAYLOAD) |=> r_byte_count == $past(count_inc))
        else $error("payload byte count did not advance");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_res_ready) |=> $stable(r_phase) && $stable(r_sum_high))
        else $error("frame state changed while stalled");

endmodule

@@ hw/rtl/mpd_out_reg.sv @@
module mpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  mpd_pkg::t_result i_res,
    output logic             o_res_ready,
    mpd_out_if.source        o_out
);

    logic             r_valid;
    mpd_pkg::t_result r_res;

    assign o_res_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_res.kind;
    assign o_out.data_byte      = r_res.data_byte;
    assign o_out.byte_index     = r_res.byte_index;
    assign o_out.status         = r_res.status;
    assign o_out.desc_set       = r_res.desc_set;
    assign o_out.payload_length = r_res.payload_length;

endmodule

@@ hw/rtl/mip_packet_deframer.sv @@
// An accepted byte waits in the input register; its result is captured in the
// output register, which presents it to the sink. Throughput: one byte per cycle
// unless the sink stalls; the input register and the output register each hold
// one item, so a byte is taken while a result waits downstream.
// Reset is synchronous and active low; it clears the frame state to hunting and
// loads the register defaults, with sync bytes 0x75 and 0x65.
module mip_packet_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpd_cfg_if.sink   i_cfg,
    mpd_in_if.sink    i_in,
    mpd_out_if.source o_out
);

    mpd_pkg::t_cfg    cfg;
    mpd_pkg::t_result res;
    logic             res_valid;
    logic             res_ready;

    mpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_rx_byte   (i_in.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    mpd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

endmodule

@@ test/mpd_checker.sv @@
`timescale 1ns / 1ps

module mpd_checker
    import mpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpd_cfg_if         i_cfg,
    mpd_in_if          i_in,
    mpd_out_if         i_out,
    output int         o_failures,
    output int         o_awaited,
    output int         o_payload_items,
    output int         o_status_items,
    output logic [7:0] o_status_mask
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_SET,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_SUM_LOW,
        TAKE_SUM_HIGH
    } t_rx_phase;

    t_cfg      regs;
    t_rx_phase phase;
    t_byte     sum_lo;
    t_byte     sum_hi;
    t_byte     frame_set;
    t_byte     frame_len;
    t_byte     pos;
    t_byte     rx_sum_lo;
    t_byte     echo_cmd;
    t_byte     ack_code;
    t_result   awaited_items[$];
    t_result   got;
    t_result   want;
    int        fail_count;
    int        payload_count;
    int        status_count;
    logic [7:0] status_seen;

    task automatic fold_sum(input t_byte b);
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
    endtask

    // Advances the receive state by one byte and queues the item it produces, if any.
    task automatic deframe_byte(input t_byte b);
        t_result r;
        r = '0;
        r.status = ST_OK;
        case (phase)
            HUNT_SECOND: begin
                if (b == regs.sync_second) begin
                    sum_lo = '0;
                    sum_hi = '0;
                    fold_sum(regs.sync_first);
                    fold_sum(regs.sync_second);
                    echo_cmd = '0;
                    ack_code = '0;
                    pos = '0;
                    phase = TAKE_SET;
                end else if (b != regs.sync_first) begin
                    phase = HUNT_FIRST;
                end
            end
            TAKE_SET: begin
                frame_set = b;
                fold_sum(b);
                phase = TAKE_LEN;
            end
            TAKE_LEN: begin
                frame_len = b;
                fold_sum(b);
                pos = '0;
                phase = (b == 8'd0) ? TAKE_SUM_LOW : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
                fold_sum(b);
                if (pos == ECHO_INDEX) echo_cmd = b;
                if (pos == ERROR_INDEX) ack_code = b;
                r.kind = KIND_PAYLOAD;
                r.data_byte = b;
                r.byte_index = pos;
                r.desc_set = frame_set;
                r.payload_length = frame_len;
                awaited_items = {awaited_items, r};
                pos = pos + 8'd1;
                if (pos == frame_len) phase = TAKE_SUM_LOW;
            end
            TAKE_SUM_LOW: begin
                rx_sum_lo = b;
                phase = TAKE_SUM_HIGH;
            end
            TAKE_SUM_HIGH: begin
                if (rx_sum_lo != sum_lo || b != sum_hi) r.status = ST_BAD_SUM;
                else if (!regs.check_ack) r.status = ST_OK;
                else if (frame_len < MIN_ACK_LENGTH) r.status = ST_TOO_SHORT;
                else if (frame_set != regs.expected_desc_set) r.status = ST_WRONG_SET;
                else if (echo_cmd != regs.expected_cmd) r.status = ST_WRONG_ECHO;
                else if (ack_code != ACK_OK_CODE) r.status = ST_NACK;
                else r.status = ST_OK;
                r.kind = KIND_STATUS;
                r.desc_set = frame_set;
                r.payload_length = frame_len;
                awaited_items = {awaited_items, r};
                phase = HUNT_FIRST;
            end
            default: begin
                phase = (b == regs.sync_first) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = {SYNC_FIRST_RESET, SYNC_SECOND_RESET, 1'b0, 8'h00, 8'h00};
            phase = HUNT_FIRST;
            sum_lo = '0;
            sum_hi = '0;
            frame_set = '0;
            frame_len = '0;
            pos = '0;
            rx_sum_lo = '0;
            echo_cmd = '0;
            ack_code = '0;
            awaited_items.delete();
            fail_count = 0;
            payload_count = 0;
            status_count = 0;
            status_seen = '0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.kind, i_out.data_byte, i_out.byte_index, i_out.status,
                       i_out.desc_set, i_out.payload_length};
                if (awaited_items.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected item: kind=%0d data=%02h index=%0d status=%0d",
                                 got.kind, got.data_byte, got.byte_index, got.status,
                                 " set=%02h length=%0d", got.desc_set, got.payload_length);
                    end
                end else begin
                    want = awaited_items.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch: expected kind=%0d data=%02h index=%0d",
                                     want.kind, want.data_byte, want.byte_index,
                                     " status=%0d set=%02h length=%0d",
                                     want.status, want.desc_set, want.payload_length);
                            $display("          actual   kind=%0d data=%02h index=%0d",
                                     got.kind, got.data_byte, got.byte_index,
                                     " status=%0d set=%02h length=%0d",
                                     got.status, got.desc_set, got.payload_length);
                        end
                    end
                    if (want.kind == KIND_PAYLOAD) begin
                        payload_count++;
                    end else begin
                        status_count++;
                        status_seen[want.status] = 1'b1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                deframe_byte(i_in.rx_byte);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SYNC_FIRST:        regs.sync_first = i_cfg.data;
                    CFG_SYNC_SECOND:       regs.sync_second = i_cfg.data;
                    CFG_CHECK_ACK:         regs.check_ack = i_cfg.data[0];
                    CFG_EXPECTED_DESC_SET: regs.expected_desc_set = i_cfg.data;
                    CFG_EXPECTED_CMD:      regs.expected_cmd = i_cfg.data;
                    default: ;
                endcase
            end
        end
        o_failures <= fail_count;
        o_awaited <= awaited_items.size();
        o_payload_items <= payload_count;
        o_status_items <= status_count;
        o_status_mask <= status_seen;
    end

endmodule

@@ test/mip_packet_deframer_test.sv @@
`timescale 1ns / 1ps

module mip_packet_deframer_test;
    import mpd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_PHASES = 8;
    localparam int TRAFFIC_PER_PHASE = 130;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 10;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_MOSTLY
    } t_stall;

    logic i_clk;
    logic i_rst_n;

    mpd_cfg_if cfg_ch ();
    mpd_in_if  in_ch ();
    mpd_out_if out_ch ();

    int         failures;
    int         awaited;
    int         payload_items;
    int         status_items;
    logic [7:0] status_mask;

    t_cfg cur;
    t_cfg next;
    int   bytes_sent = 0;
    int   frames_sent = 0;
    int   settings = 1;
    int   burst_left = 0;
    int   cycles = 0;

    mip_packet_deframer u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    mpd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg_ch),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_failures     (failures),
        .o_awaited      (awaited),
        .o_payload_items(payload_items),
        .o_status_items (status_items),
        .o_status_mask  (status_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("run timed out after %0d cycles", cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        t_stall mode;
        int     mode_left;
        int     step;
        mode = RX_ALWAYS;
        mode_left = 0;
        step = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode = t_stall'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            step++;
            case (mode)
                RX_ALWAYS:   out_ch.ready <= 1'b1;
                RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: out_ch.ready <= (step % 6 == 0);
                default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic push_byte(input t_byte b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte set, input int len, input bit corrupt,
                              input bit ack_like);
        t_byte body[$];
        t_byte lo;
        t_byte hi;
        t_byte b;
        body = '{cur.sync_first, cur.sync_second, set, t_byte'(len)};
        for (int i = 0; i < len; i++) begin
            b = t_byte'($urandom);
            if (ack_like && i == ECHO_INDEX && $urandom_range(0, 5) != 0) b = cur.expected_cmd;
            if (ack_like && i == ERROR_INDEX && $urandom_range(0, 5) != 0) b = ACK_OK_CODE;
            body = {body, b};
        end
        lo = '0;
        hi = '0;
        foreach (body[i]) begin
            lo = lo + body[i];
            hi = hi + lo;
        end
        if (corrupt) begin
            if ($urandom_range(0, 1) == 0) lo = lo ^ t_byte'(1 << $urandom_range(0, 7));
            else hi = hi ^ t_byte'(1 << $urandom_range(0, 7));
        end
        body = {body, lo};
        body = {body, hi};
        foreach (body[i]) push_byte(body[i]);
        frames_sent++;
    endtask

    task automatic run_traffic(input int n_bytes);
        int    stop_at;
        int    pick;
        int    len;
        t_byte set;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            set = ($urandom_range(0, 3) != 0) ? cur.expected_desc_set : t_byte'($urandom);
            if (pick < 80) begin
                send_frame(set, len, $urandom_range(0, 11) == 0, $urandom_range(0, 3) != 0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) push_byte(t_byte'($urandom));
            end else if (pick < 94) begin
                // A run of first sync bytes and then whatever comes next.
                repeat ($urandom_range(1, 3)) push_byte(cur.sync_first);
                push_byte(t_byte'($urandom));
            end else begin
                // A frame cut short; the following bytes are taken as its remainder.
                push_byte(cur.sync_first);
                push_byte(cur.sync_second);
                push_byte(t_byte'($urandom));
                len = $urandom_range(1, 6);
                push_byte(t_byte'(len));
                repeat ($urandom_range(0, len - 1)) push_byte(t_byte'($urandom));
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic configure(input t_cfg c);
        write_reg(CFG_SYNC_FIRST, c.sync_first);
        write_reg(CFG_SYNC_SECOND, c.sync_second);
        write_reg(CFG_CHECK_ACK, {7'($urandom_range(0, 127)), c.check_ack});
        write_reg(CFG_EXPECTED_DESC_SET, c.expected_desc_set);
        write_reg(CFG_EXPECTED_CMD, c.expected_cmd);
        cfg_ch.valid <= 1'b0;
        cur = c;
        settings++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SYNC_FIRST;
        cfg_ch.data = '0;
        cur = {SYNC_FIRST_RESET, SYNC_SECOND_RESET, 1'b0, 8'h00, 8'h00};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(cur.sync_first);
        push_byte(8'h12);
        push_byte(cur.sync_first);
        push_byte(cur.sync_first);
        send_frame(8'h00, 0, 1'b0, 1'b0);
        send_frame(8'hFF, 1, 1'b1, 1'b0);
        run_traffic(TRAFFIC_PER_PHASE);

        for (int p = 1; p < N_PHASES; p++) begin
            settle();
            next.sync_first = t_byte'($urandom);
            next.sync_second = t_byte'($urandom);
            next.check_ack = 1'($urandom_range(0, 1));
            next.expected_desc_set = t_byte'($urandom);
            next.expected_cmd = t_byte'($urandom);
            case (p)
                1: next = {8'h00, 8'hFF, 1'b1, 8'hFF, 8'h00};
                2: next = {8'hFF, 8'h00, 1'b1, 8'h00, 8'hFF};
                3: next.check_ack = 1'b0;
                4: begin
                    next.sync_second = next.sync_first;
                    next.check_ack = 1'b1;
                end
                default: ;
            endcase
            configure(next);
            if (p == 4) send_frame(cur.expected_desc_set, 255, 1'b0, 1'b1);
            run_traffic(TRAFFIC_PER_PHASE);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d bytes in %0d whole frames under %0d register settings",
                 bytes_sent, frames_sent, settings);
        $display("checked %0d payload items and %0d status items, status codes seen %b",
                 payload_items, status_items, status_mask[5:0]);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", failures);
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_if.sv
hw/rtl/mpd_cfg_regs.sv
hw/rtl/mpd_core.sv
hw/rtl/mpd_out_reg.sv
hw/rtl/mip_packet_deframer.sv
test/mpd_checker.sv
test/mip_packet_deframer_test.sv
